@@ rtl/afmi_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, field slots and flag positions for the affine 2D matrix inverse.
package afmi_pkg;

  // Q16.16 word
  localparam int Q_W    = 32;
  localparam int FRAC_W = 16;

  // stream layout: six Q16.16 fields, flags in tuser
  localparam int N_FIELDS  = 6;
  localparam int TDATA_W   = Q_W * N_FIELDS;
  localparam int TUSER_W   = 2;
  localparam int USER_SING = 0;
  localparam int USER_OVF  = 1;

  // field slots in tdata, lowest first
  localparam int F_A = 0;
  localparam int F_B = 1;
  localparam int F_C = 2;
  localparam int F_D = 3;
  localparam int F_E = 4;
  localparam int F_F = 5;

  // lanes of the linear part: inverse a, b, d, e
  localparam int N_LIN = 4;
  localparam int L_A   = 0;
  localparam int L_B   = 1;
  localparam int L_D   = 2;
  localparam int L_E   = 3;

  // internal widths
  localparam int PROD_W    = 2 * Q_W;
  localparam int DMAG_W    = PROD_W - 1;
  localparam int SUM_W     = PROD_W + 1;
  localparam int DIV_STEPS = Q_W;

  // saturation bounds, raw two's complement
  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef logic signed [Q_W-1:0] q_t;

endpackage

@@ rtl/affine2d_matrix_inverse_top.sv @@
`timescale 1ns / 1ps
// Affine 2D matrix inverse in Q16.16: top level with the full datapath pipeline.
// Pipeline: 40 register stages from the input word to out.
// Throughput: one matrix per cycle while the output is not stalled, from the 32-stage restoring divider (one quotient
//   bit per stage, four lanes sharing the determinant) and registered 32x32 multipliers.
// in_tready drops only while the output skid register is full.
// Reset (rst_n low, synchronous) clears the valid bits; payload registers are not reset.
module affine2d_matrix_inverse_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [afmi_pkg::TDATA_W-1:0]  in_tdata,   // coef_a, coef_b, coef_c, coef_d, coef_e, coef_f
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [afmi_pkg::TDATA_W-1:0]  out_tdata,  // inv_a, inv_b, inv_c, inv_d, inv_e, inv_f
  output logic [afmi_pkg::TUSER_W-1:0]  out_tuser   // singular, overflow
);
  import afmi_pkg::*;

  localparam int OUT_W = TUSER_W + TDATA_W;

  // lanes whose numerator is negated (inverse b and d)
  localparam logic [N_LIN-1:0] LANE_FLIP = (N_LIN'(1) << L_B) | (N_LIN'(1) << L_D);

  typedef struct packed {
    logic [DMAG_W-1:0]                  dmag;
    logic [N_LIN-1:0][DMAG_W-1:0]       rem;
    logic [N_LIN-1:0][Q_W-1:0]          quo;
    logic [N_LIN-1:0]                   big;
    logic [N_LIN-1:0]                   neg;
    logic                               sing;
    logic [Q_W-1:0]                     c;
    logic [Q_W-1:0]                     f;
  } div_t;

  typedef struct packed {
    logic [N_LIN-1:0][Q_W-1:0]          r;
    logic                               ovf;
    logic                               sing;
    logic [Q_W-1:0]                     c;
    logic [Q_W-1:0]                     f;
  } lin_t;

  typedef struct packed {
    logic [N_LIN-1:0][Q_W-1:0]          r;
    logic [N_LIN-1:0][PROD_W-1:0]       p;
    logic                               ovf;
    logic                               sing;
  } mul_t;

  typedef struct packed {
    logic [N_LIN-1:0][Q_W-1:0]          r;
    logic [SUM_W-1:0]                   sx;
    logic [SUM_W-1:0]                   sy;
    logic                               ovf;
    logic                               sing;
  } sum_t;

  // ---------------------------------------------------------------------------
  // helpers

  function automatic logic signed [PROD_W-1:0] smul(input logic signed [Q_W-1:0] x,
                                                    input logic signed [Q_W-1:0] y);
    smul = x * y;
  endfunction

  // one restoring step on every lane
  function automatic div_t div_step(input div_t cur);
    div_t              nxt;
    logic [PROD_W-1:0] dext;
    logic [PROD_W-1:0] trial;
    nxt  = cur;
    dext = {1'b0, cur.dmag};
    for (int i = 0; i < N_LIN; i++) begin
      trial = {cur.rem[i], 1'b0};
      if (trial >= dext) begin
        nxt.rem[i] = DMAG_W'(trial - dext);
        nxt.quo[i] = {cur.quo[i][Q_W-2:0], 1'b1};
      end else begin
        nxt.rem[i] = trial[DMAG_W-1:0];
        nxt.quo[i] = {cur.quo[i][Q_W-2:0], 1'b0};
      end
    end
    return nxt;
  endfunction

  // sign and saturate one quotient: {ovf, value}
  function automatic logic [Q_W:0] sat_lin(input logic [Q_W-1:0] quo,
                                           input logic           big,
                                           input logic           neg);
    logic           ovf;
    logic [Q_W-1:0] val;
    ovf = 1'b0;
    val = '0;
    if (big) begin
      ovf = 1'b1;
      val = neg ? Q_MIN : Q_MAX;
    end else if (quo == '0) begin
      val = '0;
    end else if (neg) begin
      if (quo > Q_MIN) begin
        ovf = 1'b1;
        val = Q_MIN;
      end else begin
        val = -quo;
      end
    end else if (quo[Q_W-1]) begin
      ovf = 1'b1;
      val = Q_MAX;
    end else begin
      val = quo;
    end
    return {ovf, val};
  endfunction

  // -(x + y) with both products sign-extended
  function automatic logic signed [SUM_W-1:0] neg_sum(input logic signed [PROD_W-1:0] x,
                                                      input logic signed [PROD_W-1:0] y);
    logic signed [SUM_W-1:0] xe;
    logic signed [SUM_W-1:0] ye;
    xe = x;
    ye = y;
    neg_sum = -xe - ye;
  endfunction

  // drop the fraction toward zero and clamp: {ovf, value}
  function automatic logic [Q_W:0] trunc_clamp(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0]        adj;
    logic [SUM_W-FRAC_W-1:0] qv;
    logic                    ovf;
    logic [Q_W-1:0]          val;
    adj = s[SUM_W-1] ? (s + SUM_W'((1 << FRAC_W) - 1)) : s;
    qv  = adj[SUM_W-1:FRAC_W];
    if ((&qv[SUM_W-FRAC_W-1:Q_W-1]) || !(|qv[SUM_W-FRAC_W-1:Q_W-1])) begin
      ovf = 1'b0;
      val = qv[Q_W-1:0];
    end else begin
      ovf = 1'b1;
      val = qv[SUM_W-FRAC_W-1] ? Q_MIN : Q_MAX;
    end
    return {ovf, val};
  endfunction

  // ---------------------------------------------------------------------------
  // flow control: whole pipe holds while the skid register is full

  logic pipe_en;
  logic skid_v_r;

  assign pipe_en   = !skid_v_r;
  assign in_tready = pipe_en;

  // unpack the input word
  q_t in_coef [N_FIELDS];

  always_comb begin
    for (int i = 0; i < N_FIELDS; i++) begin
      in_coef[i] = q_t'(in_tdata[i*Q_W +: Q_W]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: determinant products

  logic                      v1_r;
  logic signed [PROD_W-1:0]  ae1_r;
  logic signed [PROD_W-1:0]  bd1_r;
  q_t                        coef1_r [N_FIELDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ae1_r   <= smul(in_coef[F_A], in_coef[F_E]);
      bd1_r   <= smul(in_coef[F_B], in_coef[F_D]);
      coef1_r <= in_coef;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: determinant, fits 64 bits for every input

  logic                      v2_r;
  logic signed [PROD_W-1:0]  det2_r;
  q_t                        coef2_r [N_FIELDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (pipe_en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      det2_r  <= ae1_r - bd1_r;
      coef2_r <= coef1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: magnitudes and result signs

  logic                        v3_r;
  logic [DMAG_W-1:0]           dmag3_r;
  logic                        sing3_r;
  logic [N_LIN-1:0][Q_W-1:0]   nmag3_r;
  logic [N_LIN-1:0]            neg3_r;
  logic [Q_W-1:0]              c3_r;
  logic [Q_W-1:0]              f3_r;

  logic [DMAG_W-1:0]           dmag3_nxt;
  logic [N_LIN-1:0][Q_W-1:0]   nmag3_nxt;
  logic [N_LIN-1:0]            neg3_nxt;

  always_comb begin
    logic [PROD_W-1:0] dabs;
    q_t                num [N_LIN];
    num[L_A] = coef2_r[F_E];
    num[L_B] = coef2_r[F_B];
    num[L_D] = coef2_r[F_D];
    num[L_E] = coef2_r[F_A];
    dabs      = det2_r[PROD_W-1] ? -det2_r : det2_r;
    dmag3_nxt = dabs[DMAG_W-1:0];
    for (int i = 0; i < N_LIN; i++) begin
      nmag3_nxt[i] = num[i][Q_W-1] ? Q_W'(-num[i]) : Q_W'(num[i]);
      neg3_nxt[i]  = num[i][Q_W-1] ^ LANE_FLIP[i] ^ det2_r[PROD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (pipe_en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dmag3_r <= dmag3_nxt;
      sing3_r <= (det2_r == '0);
      nmag3_r <= nmag3_nxt;
      neg3_r  <= neg3_nxt;
      c3_r    <= coef2_r[F_C];
      f3_r    <= coef2_r[F_F];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4 and divider: quotient (nmag << 32) / dmag, one bit per stage.
  // A numerator not below the divisor gives a quotient of 2^32 or more, which
  // always saturates, so that lane runs on a zero remainder.

  logic [DIV_STEPS:0] dv_r;
  div_t               div_r   [DIV_STEPS+1];
  div_t               div0_nxt;
  div_t               div_nxt [DIV_STEPS];

  always_comb begin
    div0_nxt.dmag = dmag3_r;
    div0_nxt.quo  = '0;
    div0_nxt.neg  = neg3_r;
    div0_nxt.sing = sing3_r;
    div0_nxt.c    = c3_r;
    div0_nxt.f    = f3_r;
    for (int i = 0; i < N_LIN; i++) begin
      div0_nxt.big[i] = DMAG_W'(nmag3_r[i]) >= dmag3_r;
      div0_nxt.rem[i] = div0_nxt.big[i] ? '0 : DMAG_W'(nmag3_r[i]);
    end
  end

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      div_nxt[j] = div_step(div_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (pipe_en) begin
      dv_r <= {dv_r[DIV_STEPS-1:0], v3_r};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      div_r[0] <= div0_nxt;
      for (int j = 0; j < DIV_STEPS; j++) begin
        div_r[j+1] <= div_nxt[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // linear entries: sign, saturate, zero on a singular matrix

  logic vl_r;
  lin_t lin_r;
  lin_t lin_nxt;

  always_comb begin
    logic [Q_W:0]     res;
    logic [N_LIN-1:0] lane_ovf;
    div_t             dq;
    dq           = div_r[DIV_STEPS];
    lin_nxt.sing = dq.sing;
    lin_nxt.c    = dq.c;
    lin_nxt.f    = dq.f;
    for (int i = 0; i < N_LIN; i++) begin
      res          = sat_lin(dq.quo[i], dq.big[i], dq.neg[i]);
      lane_ovf[i]  = res[Q_W] && !dq.sing;
      lin_nxt.r[i] = dq.sing ? '0 : res[Q_W-1:0];
    end
    lin_nxt.ovf = |lane_ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= 1'b0;
    end else if (pipe_en) begin
      vl_r <= dv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      lin_r <= lin_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // translation products

  logic vm_r;
  mul_t mul_r;
  mul_t mul_nxt;

  always_comb begin
    mul_nxt.r       = lin_r.r;
    mul_nxt.ovf     = lin_r.ovf;
    mul_nxt.sing    = lin_r.sing;
    mul_nxt.p[L_A]  = smul(lin_r.r[L_A], lin_r.c);
    mul_nxt.p[L_B]  = smul(lin_r.r[L_B], lin_r.f);
    mul_nxt.p[L_D]  = smul(lin_r.r[L_D], lin_r.c);
    mul_nxt.p[L_E]  = smul(lin_r.r[L_E], lin_r.f);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (pipe_en) begin
      vm_r <= vl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mul_r <= mul_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // negated dot products

  logic vs_r;
  sum_t sum_r;
  sum_t sum_nxt;

  always_comb begin
    sum_nxt.r    = mul_r.r;
    sum_nxt.ovf  = mul_r.ovf;
    sum_nxt.sing = mul_r.sing;
    sum_nxt.sx   = neg_sum(mul_r.p[L_A], mul_r.p[L_B]);
    sum_nxt.sy   = neg_sum(mul_r.p[L_D], mul_r.p[L_E]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else if (pipe_en) begin
      vs_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sum_r <= sum_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // final truncate and clamp, packed into the result word

  logic [OUT_W-1:0] fin_word;

  always_comb begin
    logic [Q_W:0] tx;
    logic [Q_W:0] ty;
    tx = trunc_clamp(sum_r.sx);
    ty = trunc_clamp(sum_r.sy);
    fin_word = '0;
    fin_word[F_A*Q_W +: Q_W]          = sum_r.r[L_A];
    fin_word[F_B*Q_W +: Q_W]          = sum_r.r[L_B];
    fin_word[F_C*Q_W +: Q_W]          = tx[Q_W-1:0];
    fin_word[F_D*Q_W +: Q_W]          = sum_r.r[L_D];
    fin_word[F_E*Q_W +: Q_W]          = sum_r.r[L_E];
    fin_word[F_F*Q_W +: Q_W]          = ty[Q_W-1:0];
    fin_word[TDATA_W + USER_SING]     = sum_r.sing;
    fin_word[TDATA_W + USER_OVF]      = sum_r.ovf || tx[Q_W] || ty[Q_W];
  end

  // ---------------------------------------------------------------------------
  // output register with skid: a stalled word parks in the skid register

  logic             out_v_r;
  logic             out_v_nxt;
  logic             skid_v_nxt;
  logic             out_load;
  logic             skid_load;
  logic [OUT_W-1:0] out_word_r;
  logic [OUT_W-1:0] out_word_nxt;
  logic [OUT_W-1:0] skid_word_r;

  always_comb begin
    skid_load    = !skid_v_r && vs_r && out_v_r && !out_tready;
    out_load     = skid_v_r ? out_tready : (vs_r && (!out_v_r || out_tready));
    out_word_nxt = skid_v_r ? skid_word_r : fin_word;
    if (skid_v_r) begin
      out_v_nxt  = 1'b1;
      skid_v_nxt = !out_tready;
    end else begin
      out_v_nxt  = vs_r || (out_v_r && !out_tready);
      skid_v_nxt = skid_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= out_word_nxt;
    end
    if (skid_load) begin
      skid_word_r <= fin_word;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_word_r[TDATA_W-1:0];
  assign out_tuser  = out_word_r[TDATA_W +: TUSER_W];

endmodule

@@ rtl/afmi_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the affine 2D matrix inverse, bound to the top level.
module afmi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [afmi_pkg::TDATA_W-1:0]  out_tdata,   // inv_a, inv_b, inv_c, inv_d, inv_e, inv_f
  input logic [afmi_pkg::TUSER_W-1:0]  out_tuser    // singular, overflow
);
  import afmi_pkg::*;

  // a singular matrix yields an all-zero word and never saturates
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[USER_SING]) |-> (out_tdata == '0 && !out_tuser[USER_OVF]))
    else $error("singular result carries nonzero data or overflow");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("output word changed while stalled");

  // the input side only stalls behind a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && $past(out_tvalid && !out_tready)))
    else $error("in_tready low without a stalled output");

  // once the output drains, the input opens again
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_tready && out_tready) |=> in_tready)
    else $error("in_tready stayed low after output was taken");

  // handshake controls are never unknown once out of reset
  a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tvalid, in_tready, out_tvalid, out_tready}))
    else $error("unknown value on a handshake control");

endmodule

bind affine2d_matrix_inverse_top afmi_checker u_afmi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/affine2d_matrix_inverse_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking stream testbench for the affine 2D matrix inverse: directed table, random matrices.
module affine2d_matrix_inverse_top_test;
  import afmi_pkg::*;

  localparam int N_DIR        = 21;
  localparam int N_RANDOM     = 1380;
  localparam int CALM_TAIL    = 200;     // final random words run with no idling
  localparam int DRAIN_CYCLES = 60;      // pipeline is 40 stages deep
  localparam int TIMEOUT_NS   = 400000;

  localparam q_t ONE = 32'sh0001_0000;
  localparam q_t QMX = Q_MAX;
  localparam q_t QMN = Q_MIN;

  // a sits in the lowest 32 bits of tdata
  typedef struct packed { q_t f, e, d, c, b, a; } affine_t;

  typedef struct {
    affine_t m;
    logic    singular;
    logic    overflow;
  } inverse_t;

  typedef enum bit {FROM_MODEL, FROM_TABLE} source_e;
  typedef enum int {MAG_FULL, MAG_UNIT, MAG_TINY, MAG_EDGE} mag_e;
  typedef enum int {SH_FREE, SH_UNIT, SH_SINGULAR, SH_NEAR, SH_TINY} shape_e;

  // one directed row: coefficients, where the answer comes from, typed answer
  typedef struct packed {
    q_t      a, b, c, d, e, f;
    source_e src;
    q_t      ra, rb, rc, rd, re, rf;
    logic    sing, ovf;
  } vector_t;

  localparam vector_t DIRECTED [N_DIR] = '{
    // identity, with and without translation
    '{ONE, 0, 0, 0, ONE, 0, FROM_TABLE, ONE, 0, 0, 0, ONE, 0, 1'b0, 1'b0},
    '{ONE, 0, 32'h0003_0000, 0, ONE, 32'hFFFE_0000,
      FROM_TABLE, ONE, 0, 32'hFFFD_0000, 0, ONE, 32'h0002_0000, 1'b0, 1'b0},
    // negating the most negative offset saturates
    '{ONE, 0, QMN, 0, ONE, QMX, FROM_TABLE, ONE, 0, QMX, 0, ONE, 32'h8000_0001, 1'b0, 1'b1},
    // zero determinant in several forms
    '{0, 0, QMX, 0, 0, QMN, FROM_TABLE, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0},
    '{ONE, ONE, ONE, ONE, ONE, ONE, FROM_TABLE, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0},
    '{QMN, QMN, QMN, QMN, QMN, QMX, FROM_TABLE, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0},
    '{QMX, QMX, 0, QMX, QMX, 0, FROM_TABLE, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0},
    '{-1, -1, -1, -1, -1, -1, FROM_TABLE, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0},
    // smallest determinants: linear entries clamp
    '{1, 0, 0, 0, 1, 0, FROM_TABLE, QMX, 0, 0, 0, QMX, 0, 1'b0, 1'b1},
    '{-1, 0, 0, 0, 1, 0, FROM_TABLE, QMN, 0, 0, 0, QMX, 0, 1'b0, 1'b1},
    '{0, 1, 0, 1, 0, 0, FROM_TABLE, 0, QMX, 0, QMX, 0, 0, 1'b0, 1'b1},
    // the rest against the predictor
    '{32'h0002_0000, 0, ONE, 0, 32'h0002_0000, 0, FROM_MODEL, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0},
    '{QMN, QMN, QMX, QMX, QMN, QMN, FROM_MODEL, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0},
    '{QMX, QMX, QMN, QMX, QMN, QMX, FROM_MODEL, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0},
    '{0, -ONE, 32'h0005_0000, ONE, 0, 32'hFFFF_0000,
      FROM_MODEL, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0},
    '{QMX, 0, QMX, 0, QMX, QMN, FROM_MODEL, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0},
    '{ONE, 32'h0000_8000, 32'h1234_5678, 0, ONE, 32'hFEDC_BA98,
      FROM_MODEL, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0},
    '{32'h0003_0000, 32'h0005_0000, 32'h0001_1111, 32'h0007_0000, 32'h0002_0000,
      32'hFFF0_0000, FROM_MODEL, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0},
    '{32'h0000_0100, 0, 32'h7FFF_0000, 0, 32'h0000_0100, 32'h8001_0000,
      FROM_MODEL, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0},
    '{32'h0000_0010, 0, 32'h0008_0000, 0, 32'h0000_0010, 32'hFFF8_0000,
      FROM_MODEL, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0},
    '{QMN, QMX, 1, ONE, QMN, -1, FROM_MODEL, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0}
  };

  localparam q_t EDGE_VALS [8] = '{QMN, QMX, 0, -1, 1, ONE, -ONE, 32'sh0000_8000};

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;
  logic [TUSER_W-1:0]  out_tuser;

  inverse_t pending_q [$];
  int       fail_cnt       = 0;
  int       result_cnt     = 0;
  int       sing_cnt       = 0;
  int       ovf_cnt        = 0;
  int       src_idle_pct   = 0;
  int       sink_stall_pct = 0;
  int       sink_hold      = 0;

  affine2d_matrix_inverse_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // num / det as Q16.16, truncated toward zero, clamped; flip negates the numerator
  function automatic q_t div_by_det(q_t num, bit flip, longint unsigned det_mag, bit det_neg,
                                    inout bit ovf);
    longint          num_l;
    longint unsigned quo;
    bit              neg;
    num_l = num;
    neg   = ((num_l < 0) ^ flip) ^ det_neg;
    quo   = (num_l < 0) ? -num_l : num_l;
    quo   = (quo << 32) / det_mag;
    if (quo == 0) return '0;
    if (neg) begin
      if (quo > 64'd2147483648) begin
        ovf = 1'b1;
        return QMN;
      end
      return q_t'(-quo);
    end
    if (quo > 64'd2147483647) begin
      ovf = 1'b1;
      return QMX;
    end
    return q_t'(quo);
  endfunction

  // -(p*x + r*y) with exact products, back to Q16.16 toward zero, clamped
  function automatic q_t neg_dot(q_t p, q_t x, q_t r, q_t y, inout bit ovf);
    longint acc;
    acc = (-(longint'(p) * longint'(x)) - longint'(r) * longint'(y)) / 65536;
    if (acc > 64'sd2147483647) begin
      ovf = 1'b1;
      return QMX;
    end
    if (acc < -64'sd2147483648) begin
      ovf = 1'b1;
      return QMN;
    end
    return q_t'(acc);
  endfunction

  function automatic inverse_t invert_affine(affine_t m);
    q_t              a, b, c, d, e, f;
    longint          det;
    longint unsigned det_mag;
    bit              det_neg, ovf;
    inverse_t        res;
    {f, e, d, c, b, a} = m;
    res.m        = '0;
    res.singular = 1'b0;
    res.overflow = 1'b0;
    ovf          = 1'b0;
    det = longint'(a) * longint'(e) - longint'(b) * longint'(d);
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    det_neg = det < 0;
    det_mag = det_neg ? -det : det;
    res.m.a = div_by_det(e, 1'b0, det_mag, det_neg, ovf);
    res.m.b = div_by_det(b, 1'b1, det_mag, det_neg, ovf);
    res.m.d = div_by_det(d, 1'b1, det_mag, det_neg, ovf);
    res.m.e = div_by_det(a, 1'b0, det_mag, det_neg, ovf);
    // translation uses the already clamped linear entries
    res.m.c = neg_dot(res.m.a, c, res.m.b, f, ovf);
    res.m.f = neg_dot(res.m.d, c, res.m.e, f, ovf);
    res.overflow = ovf;
    return res;
  endfunction

  function automatic q_t rand_coef(mag_e mag);
    q_t v;
    case (mag)
      MAG_FULL: v = $urandom;
      MAG_UNIT: v = $urandom_range(0, 32'h0004_0000);   // up to 4.0
      MAG_TINY: v = $urandom_range(0, 255);
      default:  v = EDGE_VALS[$urandom_range(0, 7)];
    endcase
    if ((mag == MAG_UNIT || mag == MAG_TINY) && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic void check_word(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      fail_cnt++;
    end
  endfunction

  // drive one matrix word, with an optional idle burst ahead of it
  task automatic send_matrix(input affine_t m, input inverse_t want);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(want);
  endtask

  // result side back-pressure: out_tready dropped at random, at the rate set by sink_stall_pct
  always @(posedge clk) begin
    if (sink_hold != 0) sink_hold <= sink_hold - 1;
    else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
      out_tready <= 1'b0;
      sink_hold  <= $urandom_range(0, 3);
    end else out_tready <= 1'b1;
  end

  // compare each accepted result word with the oldest expected inverse
  always @(posedge clk) begin : result_check
    inverse_t want;
    affine_t  got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      result_cnt++;
      if (out_tuser[USER_SING]) sing_cnt++;
      if (out_tuser[USER_OVF]) ovf_cnt++;
      if (pending_q.size() == 0) begin
        $error("result word with no matrix outstanding");
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        check_word("inv_a", want.m.a, got.a);
        check_word("inv_b", want.m.b, got.b);
        check_word("inv_c", want.m.c, got.c);
        check_word("inv_d", want.m.d, got.d);
        check_word("inv_e", want.m.e, got.e);
        check_word("inv_f", want.m.f, got.f);
        check_word("singular", want.singular, out_tuser[USER_SING]);
        check_word("overflow", want.overflow, out_tuser[USER_OVF]);
      end
    end
  end

  initial begin : stimulus
    affine_t  m;
    inverse_t want;
    shape_e   shape;
    int       k;
    int       pick;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    src_idle_pct   = 20;
    sink_stall_pct = 20;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      m = {DIRECTED[i].f, DIRECTED[i].e, DIRECTED[i].d,
           DIRECTED[i].c, DIRECTED[i].b, DIRECTED[i].a};
      if (DIRECTED[i].src == FROM_TABLE) begin
        want.m = {DIRECTED[i].rf, DIRECTED[i].re, DIRECTED[i].rd,
                  DIRECTED[i].rc, DIRECTED[i].rb, DIRECTED[i].ra};
        want.singular = DIRECTED[i].sing;
        want.overflow = DIRECTED[i].ovf;
      end else want = invert_affine(m);
      send_matrix(m, want);
    end

    // random matrices, idling rates reshuffled every hundred words
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) begin
        pick = $urandom_range(0, 2);
        src_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
        pick = $urandom_range(0, 2);
        sink_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
      end
      if (i >= N_RANDOM - CALM_TAIL) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      pick  = $urandom_range(0, 99);
      shape = (pick < 30) ? SH_FREE : (pick < 65) ? SH_UNIT :
              (pick < 75) ? SH_SINGULAR : (pick < 90) ? SH_NEAR : SH_TINY;
      m.c = rand_coef(mag_e'($urandom_range(0, 3)));
      m.f = rand_coef(mag_e'($urandom_range(0, 3)));
      case (shape)
        SH_FREE: begin
          m.a = rand_coef(mag_e'($urandom_range(0, 3)));
          m.b = rand_coef(mag_e'($urandom_range(0, 3)));
          m.d = rand_coef(mag_e'($urandom_range(0, 3)));
          m.e = rand_coef(mag_e'($urandom_range(0, 3)));
        end
        SH_UNIT: begin
          m.a = rand_coef(MAG_UNIT);
          m.b = rand_coef(MAG_UNIT);
          m.d = rand_coef(MAG_UNIT);
          m.e = rand_coef(MAG_UNIT);
        end
        SH_TINY: begin
          m.a = rand_coef(MAG_TINY);
          m.b = rand_coef(MAG_TINY);
          m.d = rand_coef(MAG_TINY);
          m.e = rand_coef(MAG_TINY);
        end
        default: begin
          // proportional rows give a zero determinant; near case nudges e off it
          if ($urandom_range(0, 1) == 1) begin
            m.a = $urandom;
            m.b = $urandom;
            m.d = m.a;
            m.e = m.b;
          end else begin
            k   = $urandom_range(0, 6) - 3;
            m.a = rand_coef(MAG_UNIT);
            m.b = rand_coef(MAG_UNIT);
            m.d = m.a * k;
            m.e = m.b * k;
          end
          if (shape == SH_NEAR) m.e = m.e + q_t'($urandom_range(0, 6)) - 3;
        end
      endcase
      send_matrix(m, invert_affine(m));
    end
    in_tvalid <= 1'b0;

    // drain
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d inverses checked (%0d table rows, %0d random matrices)",
             result_cnt, N_DIR, N_RANDOM);
    $display("%0d singular and %0d saturated results seen", sing_cnt, ovf_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/afmi_pkg.sv
rtl/affine2d_matrix_inverse_top.sv
rtl/afmi_checker.sv
tb/affine2d_matrix_inverse_top_test.sv
